>>> design/mbtcp_pkg.sv
package mbtcp_pkg;

    // Position of a byte within its ADU
    typedef logic [16:0] offset_t;

    // Per-item status code
    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_LEN_ERR = 2'd1,
        STATUS_TRUNC   = 2'd2,
        STATUS_SHORT   = 2'd3
    } status_t;

    // MBAP header offsets
    localparam offset_t OFF_TID_HI  = 17'd0;
    localparam offset_t OFF_TID_LO  = 17'd1;
    localparam offset_t OFF_LEN_HI  = 17'd4;
    localparam offset_t OFF_LEN_LO  = 17'd5;
    localparam offset_t OFF_UNIT    = 17'd6;
    localparam offset_t OFF_FUNC    = 17'd7;

    // ADU spans 6 + length bytes, so the last offset is length + 5
    localparam offset_t LAST_ADJUST = 17'd5;
    localparam logic [15:0] MIN_LENGTH = 16'd2;
    localparam logic [3:0]  MIN_PACKET = 4'd8;

    // Deframer state carried between items
    typedef struct packed {
        offset_t     offset_count;
        logic [15:0] length;
        logic [15:0] transaction;
        logic [7:0]  unit;
        logic [7:0]  func;
        logic        discard;
        logic [3:0]  packet_bytes;
    } state_t;

    // One result item
    typedef struct packed {
        logic [7:0]  out_byte;
        logic        in_adu;
        offset_t     byte_offset;
        logic        adu_first;
        logic        adu_last;
        logic [15:0] transaction_ident;
        logic [15:0] length_value;
        logic [7:0]  unit_ident;
        logic [7:0]  func_code;
        status_t     status;
    } result_t;

endpackage

>>> design/modbus_tcp_adu_deframer.sv
// Modbus TCP ADU deframer: tags each payload byte with its ADU position.
// Each accepted byte's result item is registered and appears on m_ in the next cycle.
// Throughput: one byte per cycle; the single output register is the only
// stage, and s_tready stays high while that register is empty or drained.
// Reset (aresetn low, synchronous) clears all deframer state and m_tvalid.
module modbus_tcp_adu_deframer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // packet_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // [7:0] out_byte, [24:8] byte_offset,
                                   // [40:25] transaction_ident,
                                   // [56:41] length_value, [64:57] unit_ident,
                                   // [72:65] func_code, [79:73] zero
    output logic [3:0]  m_tuser,   // [0] in_adu, [1] adu_first, [3:2] status
    output logic        m_tlast    // adu_last
);
    import mbtcp_pkg::*;

    state_t  state_reg;
    state_t  state_next;
    result_t result_reg;
    result_t result_next;
    logic    valid_reg;
    logic    accept;

    mbtcp_step u_step (
        .cur        (state_reg),
        .data_byte  (s_tdata),
        .packet_end (s_tlast),
        .nxt        (state_next),
        .res        (result_next)
    );

    assign s_tready = !valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    // Deframer state and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
            valid_reg <= 1'b0;
        end else if (accept) begin
            state_reg <= state_next;
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            result_reg <= result_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {7'b0, result_reg.func_code, result_reg.unit_ident,
                       result_reg.length_value, result_reg.transaction_ident,
                       result_reg.byte_offset, result_reg.out_byte};
    assign m_tuser  = {result_reg.status, result_reg.adu_first, result_reg.in_adu};
    assign m_tlast  = result_reg.adu_last;

endmodule

>>> design/mbtcp_step.sv
module mbtcp_step (
    input  mbtcp_pkg::state_t  cur,
    input  logic [7:0]         data_byte,
    input  logic               packet_end,
    output mbtcp_pkg::state_t  nxt,
    output mbtcp_pkg::result_t res
);
    import mbtcp_pkg::*;

    offset_t     off;
    offset_t     last_off;
    logic [15:0] len_now;

    // Header capture, ADU boundary and error detection for one byte
    always_comb begin
        nxt      = cur;
        off      = cur.offset_count;
        len_now  = {cur.length[15:8], data_byte};
        last_off = {1'b0, cur.length} + LAST_ADJUST;

        res.out_byte    = data_byte;
        res.in_adu      = 1'b0;
        res.byte_offset = '0;
        res.adu_first   = 1'b0;
        res.adu_last    = 1'b0;
        res.status      = STATUS_OK;

        // saturating packet byte count
        if (cur.packet_bytes < MIN_PACKET) begin
            nxt.packet_bytes = cur.packet_bytes + 4'd1;
        end

        if (!cur.discard) begin
            res.in_adu      = 1'b1;
            res.byte_offset = off;
            res.adu_first   = (off == OFF_TID_HI);

            case (off)
                OFF_TID_HI: nxt.transaction = {data_byte, 8'h00};
                OFF_TID_LO: nxt.transaction = {cur.transaction[15:8], data_byte};
                OFF_LEN_HI: nxt.length      = {data_byte, 8'h00};
                OFF_LEN_LO: nxt.length      = len_now;
                OFF_UNIT:   nxt.unit        = data_byte;
                OFF_FUNC:   nxt.func        = data_byte;
                default:    ;
            endcase

            if (off == OFF_LEN_LO && len_now < MIN_LENGTH) begin
                res.status       = STATUS_LEN_ERR;
                nxt.discard      = 1'b1;
                nxt.offset_count = '0;
            end else if (off >= OFF_FUNC && off == last_off) begin
                res.adu_last     = 1'b1;
                nxt.offset_count = '0;
            end else begin
                nxt.offset_count = off + 17'd1;
                if (packet_end) begin
                    res.status = STATUS_TRUNC;
                end
            end
        end

        // end of packet: short check wins, per-packet state clears
        if (packet_end) begin
            if (nxt.packet_bytes < MIN_PACKET) begin
                res.status = STATUS_SHORT;
            end
            nxt.offset_count = '0;
            nxt.discard      = 1'b0;
            nxt.packet_bytes = '0;
        end

        res.transaction_ident = nxt.transaction;
        res.length_value      = nxt.length;
        res.unit_ident        = nxt.unit;
        res.func_code         = nxt.func;
    end

endmodule

>>> design/mbtcp_chk.sv
module mbtcp_chk (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [7:0]  s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [79:0] m_tdata,
    input logic [3:0]  m_tuser,
    input logic        m_tlast
);
    import mbtcp_pkg::*;

    // output item holds until taken
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result item dropped while stalled");

    // an accepted byte appears as the result item's data byte in the next cycle
    a_pass: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> m_tvalid && m_tdata[7:0] == $past(s_tdata))
        else $error("result item does not follow accepted byte");

    // discarded bytes carry no position or marks
    a_discard: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |->
            m_tdata[24:8] == 17'd0 && !m_tuser[1] && !m_tlast)
        else $error("discarded byte carries ADU marks");

    // last byte of an ADU lies at or past the function code
    a_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tuser[0] && m_tdata[24:8] >= OFF_FUNC)
        else $error("ADU end marked inside header");

    // length error is only reported on the low length byte
    a_lenerr: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[3:2] == STATUS_LEN_ERR |->
            m_tuser[0] && m_tdata[24:8] == OFF_LEN_LO)
        else $error("length error off the length field");

endmodule

bind modbus_tcp_adu_deframer mbtcp_chk u_mbtcp_chk (.*);
